// ===== rtl/core/swm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and constants for the star wildcard matcher
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int PATTERN_CAPACITY = 32;
    localparam int LEN_W            = $clog2(PATTERN_CAPACITY + 1);
    localparam int IDX_W            = $clog2(PATTERN_CAPACITY);
    localparam int SCAN_LEVELS      = $clog2(PATTERN_CAPACITY + 1);

    localparam logic [7:0] STAR_SYMBOL = 8'd42;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_WORD   = 2'd2,
        CMD_END    = 2'd3
    } cmd_t;

    // pattern view presented to the position tracker
    typedef struct packed {
        logic [PATTERN_CAPACITY-1:0] star;   // position holds a star
        logic [PATTERN_CAPACITY-1:0] hit;    // literal position equals current symbol
        logic [LEN_W-1:0]            length;
        logic                        overflow;
    } pat_view_t;

    // one result word
    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } result_t;

endpackage

// ===== rtl/core/swm_pattern.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pattern
// pattern byte store, length and overflow flag, with per-position compare
// ----------------------------------------------------------------------------
module swm_pattern
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       clear,
    input  logic       append,
    input  logic [7:0] symbol,
    output pat_view_t  view
);

    logic [7:0]       store_reg [0:PATTERN_CAPACITY-1];
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic             overflow_reg;
    logic             overflow_next;
    logic             has_room;

    assign has_room = (length_reg < LEN_W'(PATTERN_CAPACITY));

    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        if (clear)
        begin
            length_next   = '0;
            overflow_next = 1'b0;
        end
        else if (append)
        begin
            if (has_room)
                length_next = length_reg + LEN_W'(1);
            else
                overflow_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
        end
    end

    // byte store, no reset: only entries below the length are ever looked at
    always_ff @(posedge clk)
    begin
        if (append && has_room)
            store_reg[length_reg[IDX_W-1:0]] <= symbol;
    end

    always_comb
    begin
        for (int i = 0; i < PATTERN_CAPACITY; i++)
        begin
            logic in_use;
            logic is_star;
            in_use      = (LEN_W'(i) < length_reg);
            is_star     = (store_reg[i] == STAR_SYMBOL);
            view.star[i] = in_use && is_star;
            view.hit[i]  = in_use && !is_star && (store_reg[i] == symbol);
        end
        view.length   = length_reg;
        view.overflow = overflow_reg;
    end

endmodule

// ===== rtl/core/swm_nfa.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_nfa
// live pattern position vector: one step per word byte, star closure by scan
// ----------------------------------------------------------------------------
module swm_nfa
    import swm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      restart,
    input  logic      feed,
    input  pat_view_t view,
    output logic      matched
);

    // held vector is pre-closure; closure is applied against the current pattern
    logic [PATTERN_CAPACITY:0] live_reg;
    logic [PATTERN_CAPACITY:0] live_next;
    logic [PATTERN_CAPACITY:0] closed;
    logic [PATTERN_CAPACITY:0] step;
    logic [PATTERN_CAPACITY:0] gen_lvl  [0:SCAN_LEVELS];
    logic [PATTERN_CAPACITY:0] prop_lvl [0:SCAN_LEVELS-1];

    // closure as a prefix scan: a live bit runs forward across a run of stars
    always_comb
    begin
        gen_lvl[0]     = live_reg;
        prop_lvl[0][0] = 1'b0;
        for (int i = 1; i <= PATTERN_CAPACITY; i++)
            prop_lvl[0][i] = view.star[i-1];
        for (int l = 0; l < SCAN_LEVELS; l++)
        begin
            for (int i = 0; i <= PATTERN_CAPACITY; i++)
            begin
                if (i >= (1 << l))
                    gen_lvl[l+1][i] = gen_lvl[l][i]
                                    | (prop_lvl[l][i] & gen_lvl[l][i - (1 << l)]);
                else
                    gen_lvl[l+1][i] = gen_lvl[l][i];
                if (l < SCAN_LEVELS - 1)
                begin
                    if (i >= (1 << l))
                        prop_lvl[l+1][i] = prop_lvl[l][i] & prop_lvl[l][i - (1 << l)];
                    else
                        prop_lvl[l+1][i] = 1'b0;
                end
            end
        end
        closed = gen_lvl[SCAN_LEVELS];
    end

    // one byte step: a star keeps its position, a matching literal advances
    always_comb
    begin
        step = '0;
        for (int i = 0; i < PATTERN_CAPACITY; i++)
        begin
            if (closed[i] && view.star[i])
                step[i] = 1'b1;
            if (closed[i] && view.hit[i])
                step[i+1] = 1'b1;
        end
    end

    always_comb
    begin
        live_next = live_reg;
        if (restart)
            live_next = (PATTERN_CAPACITY + 1)'(1);
        else if (feed)
            live_next = step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            live_reg <= (PATTERN_CAPACITY + 1)'(1);
        else
            live_reg <= live_next;
    end

    assign matched = closed[view.length];

endmodule

// ===== rtl/core/swm_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_out_buf
// result register plus one skid entry between the core and the receiver
// ----------------------------------------------------------------------------
module swm_out_buf
    import swm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    pop;

    assign pop = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = push;
                if (push)
                    skid_next = push_data;
            end
            else
            begin
                main_valid_next = push;
                if (push)
                    main_next = push_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

// ===== rtl/core/star_wildcard_matcher_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// star_wildcard_matcher_core
// matches streamed words against a stored pattern where '*' matches any run
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_ready): one word per command - clear the
//   pattern, append a pattern byte, feed a word byte, or end the word.
//   output channel (out_valid / out_ready): one word per end of word, giving
//   matched and pattern_overflow.
//   throughput: one input word every cycle while in_ready is high; every
//   command finishes in the cycle it is accepted, as all pattern positions
//   step together and the star closure is a prefix scan of log2(capacity + 1) levels.
//   output: a result is registered in the result register, or in the skid
//   entry while the result register still waits for the receiver.
//   stall: a result register and one skid entry sit in front of the
//   receiver; input stays open until both hold results, then in_ready drops.
//   reset: pattern empty, overflow clear, word restarted, no result pending.
//   pattern bytes beyond capacity are dropped and flagged until next clear.
// ----------------------------------------------------------------------------
module star_wildcard_matcher_core
    import swm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);

    logic      accept;
    logic      buf_full;
    logic      do_clear;
    logic      do_append;
    logic      do_feed;
    logic      do_end;
    pat_view_t view;
    logic      match_now;
    result_t   result;
    result_t   out_data;

    // input side stays open until the skid entry holds a result
    assign in_ready = !buf_full;
    assign accept   = in_valid && in_ready;

    // command decode
    always_comb
    begin
        do_clear  = 1'b0;
        do_append = 1'b0;
        do_feed   = 1'b0;
        do_end    = 1'b0;
        unique case (cmd_t'(command))
            CMD_CLEAR:  do_clear  = accept;
            CMD_APPEND: do_append = accept;
            CMD_WORD:   do_feed   = accept;
            CMD_END:    do_end    = accept;
            default:    do_end    = 1'b0;
        endcase
    end

    // pattern bytes, length and overflow flag
    swm_pattern u_pattern (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (do_clear),
        .append (do_append),
        .symbol (symbol),
        .view   (view)
    );

    // live positions; any command but a word byte restarts the word
    swm_nfa u_nfa (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (do_clear || do_append || do_end),
        .feed    (do_feed),
        .view    (view),
        .matched (match_now)
    );

    // result of an end of word, taken from state before this word's update
    assign result.matched          = match_now;
    assign result.pattern_overflow = view.overflow;

    swm_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (do_end),
        .push_data (result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign matched          = out_data.matched;
    assign pattern_overflow = out_data.pattern_overflow;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for star_wildcard_matcher_core: drives clear, append,
// word byte and end of word commands, predicts each end of word result with
// an independent tracker or a typed table entry, compares results in order
// ----------------------------------------------------------------------------
module tb;
    import swm_pkg::*;

    localparam int RANDOM_WORDS = 1100;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_ROWS     = 28;

    typedef logic [PATTERN_CAPACITY:0] live_t;

    // one row of the directed table; reps repeats the same word
    typedef struct {
        cmd_t       cmd;
        logic [7:0] sym;
        int         reps;
        bit         typed;
        result_t    res;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] command;
    logic [7:0] symbol;
    logic       out_valid;
    logic       out_ready;
    logic       matched;
    logic       pattern_overflow;

    // predicted pattern tracker state
    logic [7:0] pat_mem [PATTERN_CAPACITY];
    int         pat_len;
    bit         pat_ovf;
    live_t      live;

    result_t    expected_results [$];
    stim_row_t  directed_rows [NUM_ROWS];

    int errors;
    int words_in;
    int results_seen;
    int results_matched;
    int results_overflow;
    int cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req_cnt;
    int hold_seen_cnt;
    int hold_left;

    star_wildcard_matcher_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .symbol           (symbol),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .matched          (matched),
        .pattern_overflow (pattern_overflow)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t timeout after %0d cycles", $time, cycles);
            $display("star_wildcard_matcher_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // position tracker
    // ------------------------------------------------------------------------

    // a star may match an empty run, so liveness falls through it
    function automatic live_t close_stars(input live_t v);
        for (int i = 0; i < pat_len; i++)
        begin
            if (v[i] && pat_mem[i] == STAR_SYMBOL)
                v[i + 1] = 1'b1;
        end
        return v;
    endfunction

    function automatic live_t fresh_live();
        live_t v;
        v    = '0;
        v[0] = 1'b1;
        return close_stars(v);
    endfunction

    // all positions step in parallel on one word byte
    function automatic live_t step_live(input logic [7:0] c);
        live_t v;
        v = '0;
        for (int i = 0; i < pat_len; i++)
        begin
            if (live[i])
            begin
                if (pat_mem[i] == STAR_SYMBOL)
                    v[i] = 1'b1;
                else if (pat_mem[i] == c)
                    v[i + 1] = 1'b1;
            end
        end
        return close_stars(v);
    endfunction

    task automatic track_command(input cmd_t cmd, input logic [7:0] sym,
                                 output bit got, output result_t res);
        got = 1'b0;
        res = '0;
        case (cmd)
            CMD_CLEAR:
            begin
                pat_len = 0;
                pat_ovf = 1'b0;
                live    = fresh_live();
            end
            CMD_APPEND:
            begin
                if (pat_len < PATTERN_CAPACITY)
                begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end
                else
                    pat_ovf = 1'b1;
                live = fresh_live();
            end
            CMD_WORD:
                live = step_live(sym);
            default:
            begin
                got                  = 1'b1;
                res.matched          = live[pat_len];
                res.pattern_overflow = pat_ovf;
                live                 = fresh_live();
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offers one word, waits for the handshake, then updates the tracker
    task automatic drive_word(input cmd_t cmd, input logic [7:0] sym,
                              input bit typed, input result_t typed_res);
        bit      got;
        result_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        symbol   <= sym;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_command(cmd, sym, got, res);
        if (got)
            expected_results.push_back(typed ? typed_res : res);
        words_in++;
    endtask

    task automatic drive_plain(input cmd_t cmd, input logic [7:0] sym);
        drive_word(cmd, sym, 1'b0, '0);
    endtask

    // mostly a tiny alphabet so that matches happen, plus stars and any byte
    function automatic logic [7:0] pick_symbol(input int star_pct);
        int r;
        r = $urandom_range(99);
        if (r < star_pct)
            return STAR_SYMBOL;
        if (r < star_pct + 20)
            return 8'($urandom_range(255));
        case ($urandom_range(2))
            0:       return 8'h61;
            1:       return 8'h62;
            default: return 8'h63;
        endcase
    endfunction

    task automatic send_pattern();
        int n;
        if ($urandom_range(9) == 0)
            n = $urandom_range(PATTERN_CAPACITY - 2, PATTERN_CAPACITY + 4);
        else
            n = $urandom_range(0, 8);
        drive_plain(CMD_CLEAR, 8'($urandom_range(255)));
        for (int i = 0; i < n; i++)
            drive_plain(CMD_APPEND, pick_symbol(30));
    endtask

    // a word built from the current pattern, now and then slightly broken
    task automatic send_fitting_word();
        int         run;
        logic [7:0] c;
        for (int i = 0; i < pat_len; i++)
        begin
            if (pat_mem[i] == STAR_SYMBOL)
            begin
                run = $urandom_range(0, 3);
                for (int k = 0; k < run; k++)
                    drive_plain(CMD_WORD, pick_symbol(10));
            end
            else
            begin
                c = pat_mem[i];
                if ($urandom_range(99) < 4)
                    c = pick_symbol(10);
                if ($urandom_range(99) >= 2)
                    drive_plain(CMD_WORD, c);
            end
        end
        if ($urandom_range(9) == 0)
            drive_plain(CMD_WORD, pick_symbol(10));
        drive_plain(CMD_END, 8'($urandom_range(255)));
    endtask

    task automatic send_loose_word();
        int n;
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            drive_plain(CMD_WORD, pick_symbol(10));
        drive_plain(CMD_END, 8'($urandom_range(255)));
    endtask

    task automatic send_noise();
        drive_plain(cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------------
    // output side: ready pattern, long hold-off and result check
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (matched)
                    results_matched++;
                if (pattern_overflow)
                    results_overflow++;
                if (expected_results.size() == 0)
                begin
                    $display("%0t unexpected result matched=%0b pattern_overflow=%0b",
                             $time, matched, pattern_overflow);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (matched !== want.matched)
                    begin
                        $display("%0t matched mismatch: expected %0b actual %0b",
                                 $time, want.matched, matched);
                        errors++;
                    end
                    if (pattern_overflow !== want.pattern_overflow)
                    begin
                        $display("%0t pattern_overflow mismatch: expected %0b actual %0b",
                                 $time, want.pattern_overflow, pattern_overflow);
                        errors++;
                    end
                end
            end
            if (hold_req_cnt != hold_seen_cnt)
            begin
                hold_seen_cnt = hold_req_cnt;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int start;
        int r;
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        command          = CMD_CLEAR;
        symbol           = 8'h00;
        out_ready        = 1'b0;
        errors           = 0;
        words_in         = 0;
        results_seen     = 0;
        results_matched  = 0;
        results_overflow = 0;
        cycles           = 0;
        hold_req_cnt     = 0;
        hold_seen_cnt    = 0;
        hold_left        = 0;
        send_idle_pct    = 15;
        recv_idle_pct    = 68;
        pat_len          = 0;
        pat_ovf          = 1'b0;
        live             = '0;
        live[0]          = 1'b1;

        // directed table: typed results only where obvious
        directed_rows = '{
            '{CMD_END,    8'h00,        1,  1'b1, '{1'b1, 1'b0}}, // empty vs empty
            '{CMD_WORD,   8'h00,        1,  1'b0, '0},
            '{CMD_END,    8'hFF,        1,  1'b1, '{1'b0, 1'b0}}, // empty pattern, one byte
            '{CMD_APPEND, STAR_SYMBOL,  1,  1'b0, '0},
            '{CMD_END,    8'h00,        1,  1'b1, '{1'b1, 1'b0}}, // lone star, empty word
            '{CMD_WORD,   STAR_SYMBOL,  1,  1'b0, '0},
            '{CMD_WORD,   8'hFF,        1,  1'b0, '0},
            '{CMD_END,    8'h00,        1,  1'b1, '{1'b1, 1'b0}}, // lone star takes anything
            '{CMD_CLEAR,  8'hFF,        1,  1'b0, '0},
            '{CMD_APPEND, 8'h00,        1,  1'b0, '0},
            '{CMD_APPEND, STAR_SYMBOL,  1,  1'b0, '0},
            '{CMD_APPEND, 8'hFF,        1,  1'b0, '0},
            '{CMD_WORD,   8'h00,        1,  1'b0, '0},
            '{CMD_WORD,   STAR_SYMBOL,  1,  1'b0, '0}, // star byte as plain word byte
            '{CMD_WORD,   8'hFF,        1,  1'b0, '0},
            '{CMD_END,    8'h00,        1,  1'b0, '0},
            '{CMD_WORD,   8'h00,        1,  1'b0, '0},
            '{CMD_APPEND, 8'hFF,        1,  1'b0, '0}, // append in mid word restarts it
            '{CMD_WORD,   8'hFF,        1,  1'b0, '0},
            '{CMD_END,    8'h00,        1,  1'b0, '0},
            '{CMD_CLEAR,  8'h00,        1,  1'b0, '0},
            '{CMD_APPEND, 8'h61,        1,  1'b0, '0},
            '{CMD_WORD,   STAR_SYMBOL,  1,  1'b0, '0},
            '{CMD_END,    8'h00,        1,  1'b1, '{1'b0, 1'b0}}, // word star is no literal
            '{CMD_APPEND, STAR_SYMBOL,  PATTERN_CAPACITY + 8, 1'b0, '0}, // overrun
            '{CMD_END,    8'h00,        1,  1'b1, '{1'b0, 1'b1}}, // literal unmet, overflow
            '{CMD_CLEAR,  8'h00,        1,  1'b0, '0},
            '{CMD_END,    8'hFF,        1,  1'b1, '{1'b1, 1'b0}}  // clear drops overflow
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (int k = 0; k < directed_rows[i].reps; k++)
                drive_word(directed_rows[i].cmd, directed_rows[i].sym,
                           directed_rows[i].typed, directed_rows[i].res);
        end

        // random part in three idling phases
        start = words_in;
        while (words_in - start < RANDOM_WORDS)
        begin
            if (words_in - start >= 2 * RANDOM_WORDS / 3 && send_idle_pct != 0)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // long receiver hold while ends keep coming, so input backs up
                hold_req_cnt <= hold_req_cnt + 1;
                for (int k = 0; k < 12; k++)
                    drive_plain(CMD_END, 8'($urandom_range(255)));
            end
            else if (words_in - start >= RANDOM_WORDS / 3 && send_idle_pct == 15)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 15;
            end
            r = $urandom_range(99);
            if (r < 15)
                send_pattern();
            else if (r < 75)
                send_fitting_word();
            else if (r < 88)
                send_loose_word();
            else
                send_noise();
        end
        in_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input words and %0d results (%0d matched, %0d with overflow)",
                 words_in, results_seen, results_matched, results_overflow);
        $display("idling phases 15/68, 68/15 and none, with one %0d cycle receiver hold",
                 HOLD_CYCLES);
        if (errors == 0 && expected_results.size() == 0)
            $display("star_wildcard_matcher_core test passed");
        else
            $display("star_wildcard_matcher_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/swm_pkg.sv
rtl/core/swm_pattern.sv
rtl/core/swm_nfa.sv
rtl/core/swm_out_buf.sv
rtl/core/star_wildcard_matcher_core.sv
test/tb.sv
